>>> hdl/htw_pkg.sv
// Package for the hierarchical timer wheel: sizes, codes, shared types
// and the bucket selection function.
// Used by every other file of the block; depends on nothing.
package htw_pkg;

   // Wheel geometry.
   localparam int NUM_TIMERS = 64;
   localparam int SLOT_SHIFT = 6;
   localparam int INNER_BITS = 10;
   localparam int OUTER_BITS = 8;

   localparam int IN_SLOTS  = 1 << INNER_BITS;
   localparam int OUT_SLOTS = 1 << OUTER_BITS;
   localparam int NBUCKETS  = IN_SLOTS + 2 * OUT_SLOTS;
   localparam int BKT_W     = $clog2(NBUCKETS);
   localparam int ENT_AW    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   // Fixed field widths.
   localparam int ID_W   = 6;
   localparam int TIME_W = 32;
   localparam int PTR_W  = 7;
   localparam logic [PTR_W-1:0] NIL = '1;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_TICK   = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_ADDED    = 3'd0,
      KIND_REJECTED = 3'd1,
      KIND_DELETED  = 3'd2,
      KIND_IDLE     = 3'd3,
      KIND_EXPIRED  = 3'd4,
      KIND_NONE     = 3'd5,
      KIND_NOT_DUE  = 3'd6
   } kind_type;

   // One bucket: first and last entry of its list.
   typedef struct packed {
      logic [PTR_W-1:0] head;
      logic [PTR_W-1:0] tail;
   } bkt_word_type;

   // Write command to the entry store; one address, one enable per field.
   typedef struct packed {
      logic              we_exp;
      logic              we_next;
      logic              we_prev;
      logic              we_bkt;
      logic [ENT_AW-1:0] addr;
      logic [TIME_W-1:0] expiry;
      logic [PTR_W-1:0]  next;
      logic [PTR_W-1:0]  prev;
      logic [BKT_W-1:0]  bkt;
   } ent_wr_type;

   // Registered read data of the entry store.
   typedef struct packed {
      logic [TIME_W-1:0] expiry;
      logic [PTR_W-1:0]  next;
      logic [PTR_W-1:0]  prev;
      logic [BKT_W-1:0]  bkt;
   } ent_rd_type;

   // True when a link names a real entry.
   function automatic logic ptr_ok(logic [PTR_W-1:0] p);
      return ({{(32-PTR_W){1'b0}}, p} < 32'(NUM_TIMERS));
   endfunction

   // True when a timer id names a real entry.
   function automatic logic id_ok(logic [ID_W-1:0] id);
      return ({{(32-ID_W){1'b0}}, id} < 32'(NUM_TIMERS));
   endfunction

   // Bucket that a timer expiring at e belongs in, seen from wheel time wt.
   function automatic logic [BKT_W-1:0] pick_bucket(logic [TIME_W-1:0] e,
                                                    logic [TIME_W-1:0] wt,
                                                    logic [INNER_BITS-1:0] inner);
      logic [TIME_W-1:0] d;
      logic [TIME_W-1:0] sl;
      logic [BKT_W-1:0]  b;
      d = e - wt;
      if ((d >> (SLOT_SHIFT + INNER_BITS)) == '0) begin
         sl = e >> SLOT_SHIFT;
         b  = BKT_W'(sl[INNER_BITS-1:0]);
      end else if ((d >> (SLOT_SHIFT + INNER_BITS + OUTER_BITS)) == '0) begin
         sl = e >> (SLOT_SHIFT + INNER_BITS);
         b  = BKT_W'(IN_SLOTS) + BKT_W'(sl[OUTER_BITS-1:0]);
      end else if (d[TIME_W-1]) begin
         sl = '0;
         b  = BKT_W'(inner);
      end else begin
         sl = e >> (SLOT_SHIFT + INNER_BITS + OUTER_BITS);
         b  = BKT_W'(IN_SLOTS + OUT_SLOTS) + BKT_W'(sl[OUTER_BITS-1:0]);
      end
      return b;
   endfunction

endpackage

>>> hdl/htw_req_if.sv
// Request channel of the hierarchical timer wheel: valid, ready, payload.
// Depends on htw_pkg for the field widths.
interface htw_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                operation;
   logic [htw_pkg::ID_W-1:0]   timer_sel;
   logic [htw_pkg::TIME_W-1:0] expire_time;
   logic [htw_pkg::TIME_W-1:0] now_time;

   modport source (output valid, operation, timer_sel, expire_time, now_time,
                   input ready);
   modport sink (input valid, operation, timer_sel, expire_time, now_time,
                 output ready);
endinterface

>>> hdl/htw_rsp_if.sv
// Response channel of the hierarchical timer wheel: valid, ready, payload.
// Depends on htw_pkg for the field widths.
interface htw_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [2:0]              kind;
   logic [htw_pkg::ID_W-1:0] timer_out;
   logic                    last;
   logic                    behind;

   modport source (output valid, kind, timer_out, last, behind, input ready);
   modport sink (input valid, kind, timer_out, last, behind, output ready);
endinterface

>>> hdl/htw_entry_store.sv
// Per-timer storage: expiry, list links and owning bucket.
// Depends on htw_pkg. One read address and one write address per cycle.
module htw_entry_store (
   input  logic                           clock,
   input  htw_pkg::ent_wr_type            wr,
   input  logic [htw_pkg::ENT_AW-1:0]     rd_addr,
   output htw_pkg::ent_rd_type            rd
);

   logic [htw_pkg::TIME_W-1:0] exp_mem  [htw_pkg::NUM_TIMERS];
   logic [htw_pkg::PTR_W-1:0]  next_mem [htw_pkg::NUM_TIMERS];
   logic [htw_pkg::PTR_W-1:0]  prev_mem [htw_pkg::NUM_TIMERS];
   logic [htw_pkg::BKT_W-1:0]  bkt_mem  [htw_pkg::NUM_TIMERS];
   htw_pkg::ent_rd_type        rd_ff;

   // Field writes share one address.
   always_ff @(posedge clock) begin
      if (wr.we_exp)  exp_mem[wr.addr]  <= wr.expiry;
      if (wr.we_next) next_mem[wr.addr] <= wr.next;
      if (wr.we_prev) prev_mem[wr.addr] <= wr.prev;
      if (wr.we_bkt)  bkt_mem[wr.addr]  <= wr.bkt;
   end

   // Registered read of all fields of one entry.
   always_ff @(posedge clock) begin
      rd_ff.expiry <= exp_mem[rd_addr];
      rd_ff.next   <= next_mem[rd_addr];
      rd_ff.prev   <= prev_mem[rd_addr];
      rd_ff.bkt    <= bkt_mem[rd_addr];
   end

   assign rd = rd_ff;

endmodule

>>> hdl/htw_bucket_store.sv
// Bucket table of all three wheel levels: head and tail link per bucket.
// Depends on htw_pkg. Single write port, single registered read port.
module htw_bucket_store (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [htw_pkg::BKT_W-1:0]   wr_addr,
   input  htw_pkg::bkt_word_type       wr_data,
   input  logic [htw_pkg::BKT_W-1:0]   rd_addr,
   output htw_pkg::bkt_word_type       rd_data
);

   htw_pkg::bkt_word_type mem [htw_pkg::NBUCKETS];
   htw_pkg::bkt_word_type rd_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

>>> hdl/hierarchical_timer_wheel.sv
// Hierarchical timer wheel, top level: request/response channels, the
// sequencer, and the entry and bucket stores. Depends on htw_pkg, the
// channel interfaces, htw_entry_store and htw_bucket_store.
//
// Each request beat is an add, a delete or a tick. An add files a timer in
// the bucket its distance from wheel time selects; a delete unlinks it; a
// due tick cascades the outer levels at the wrap of the inner index, then
// sends one expired beat per timer of the current slot in FIFO order and
// advances one slot. Every request gives one or more response beats, the
// final one marked by last.
// One request is handled at a time; req.ready is high only between items.
// The sequencer visits the entry and bucket memories, each with one read
// and one write port, one access step at a time.
// After reset the bucket table is cleared, one bucket a cycle, with
// req.ready low. A stalled response beat holds in the output register;
// the sequencer waits before writing the next one, and the last beat of an
// item leaves the block free to take the next request.
module hierarchical_timer_wheel (
   input logic       clock,
   input logic       reset,
   htw_req_if.sink   req,
   htw_rsp_if.source rsp
);

   typedef enum logic [18:0] {
      S_CLEAR     = 19'h00001,
      S_IDLE      = 19'h00002,
      S_DECIDE    = 19'h00004,
      S_EMIT      = 19'h00008,
      S_APP_RD    = 19'h00010,
      S_APP_WR    = 19'h00020,
      S_APP_LINK  = 19'h00040,
      S_UNL_RD    = 19'h00080,
      S_UNL_BK    = 19'h00100,
      S_UNL_WR    = 19'h00200,
      S_UNL_LINK  = 19'h00400,
      S_CAS_RD    = 19'h00800,
      S_CAS_DET   = 19'h01000,
      S_CAS_CHK   = 19'h02000,
      S_CAS_FILE  = 19'h04000,
      S_EXP_START = 19'h08000,
      S_EXP_RD    = 19'h10000,
      S_EXP_CHK   = 19'h20000,
      S_EXP_TAKE  = 19'h40000
   } state_type;

   typedef enum logic [1:0] {
      CTX_ADD = 2'd0,
      CTX_DEL = 2'd1,
      CTX_CAS = 2'd2,
      CTX_EXP = 2'd3
   } ctx_type;

   localparam logic [htw_pkg::TIME_W-1:0] SLOT_TICKS =
      htw_pkg::TIME_W'(1) << htw_pkg::SLOT_SHIFT;
   localparam logic [htw_pkg::BKT_W-1:0] CLR_LAST =
      htw_pkg::BKT_W'(htw_pkg::NBUCKETS - 1);

   state_type state_ff, state_in, after_ff, after_in;
   ctx_type   ctx_ff, ctx_in;

   logic [htw_pkg::BKT_W-1:0]      clr_ff, clr_in;
   logic [1:0]                     op_ff, op_in;
   logic [htw_pkg::ID_W-1:0]       id_ff, id_in;
   logic [htw_pkg::TIME_W-1:0]     exp_ff, exp_in;
   logic [htw_pkg::TIME_W-1:0]     now_ff, now_in;
   logic [htw_pkg::TIME_W-1:0]     wheel_time_ff, wheel_time_in;
   logic [htw_pkg::INNER_BITS-1:0] inner_ff, inner_in;
   logic [htw_pkg::OUTER_BITS-1:0] middle_ff, middle_in;
   logic [htw_pkg::OUTER_BITS-1:0] outer_ff, outer_in;
   logic [htw_pkg::NUM_TIMERS-1:0] pending_ff, pending_in;
   logic [htw_pkg::PTR_W-1:0]      cur_ff, cur_in;
   logic [htw_pkg::PTR_W-1:0]      nxt_ff, nxt_in;
   logic [htw_pkg::PTR_W-1:0]      prv_ff, prv_in;
   logic [htw_pkg::BKT_W-1:0]      bkt_ff, bkt_in;
   logic                           cas_outer_ff, cas_outer_in;
   logic                           hold_valid_ff, hold_valid_in;
   logic [htw_pkg::ID_W-1:0]       hold_id_ff, hold_id_in;
   logic                           behind_ff, behind_in;

   htw_pkg::kind_type              res_kind_ff, res_kind_in;
   logic [htw_pkg::ID_W-1:0]       res_id_ff, res_id_in;
   logic                           res_last_ff, res_last_in;
   logic                           res_behind_ff, res_behind_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   htw_pkg::kind_type              rsp_kind_ff, rsp_kind_in;
   logic [htw_pkg::ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           rsp_behind_ff, rsp_behind_in;

   htw_pkg::ent_wr_type            ent_wr;
   logic [htw_pkg::ENT_AW-1:0]     ent_rd_addr;
   htw_pkg::ent_rd_type            ent_rd;
   logic                           bkt_we;
   logic [htw_pkg::BKT_W-1:0]      bkt_wr_addr;
   htw_pkg::bkt_word_type          bkt_wr_data;
   logic [htw_pkg::BKT_W-1:0]      bkt_rd_addr;
   htw_pkg::bkt_word_type          bkt_rd;

   htw_entry_store u_entry (
      .clock   (clock),
      .wr      (ent_wr),
      .rd_addr (ent_rd_addr),
      .rd      (ent_rd)
   );

   htw_bucket_store u_bucket (
      .clock   (clock),
      .wr_en   (bkt_we),
      .wr_addr (bkt_wr_addr),
      .wr_data (bkt_wr_data),
      .rd_addr (bkt_rd_addr),
      .rd_data (bkt_rd)
   );

   // Sequencer: one memory access step per cycle, except while it waits for a free output register.
   always_comb begin
      logic                        app_done;
      logic                        unl_done;
      logic [htw_pkg::TIME_W-1:0]  lag;
      logic [htw_pkg::TIME_W-1:0]  lag_next;
      logic [htw_pkg::ENT_AW-1:0]  id_idx;

      state_in      = state_ff;
      after_in      = after_ff;
      ctx_in        = ctx_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      exp_in        = exp_ff;
      now_in        = now_ff;
      wheel_time_in = wheel_time_ff;
      inner_in      = inner_ff;
      middle_in     = middle_ff;
      outer_in      = outer_ff;
      pending_in    = pending_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      prv_in        = prv_ff;
      bkt_in        = bkt_ff;
      cas_outer_in  = cas_outer_ff;
      hold_valid_in = hold_valid_ff;
      hold_id_in    = hold_id_ff;
      behind_in     = behind_ff;
      res_kind_in   = res_kind_ff;
      res_id_in     = res_id_ff;
      res_last_in   = res_last_ff;
      res_behind_in = res_behind_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_behind_in = rsp_behind_ff;

      ent_wr        = '0;
      ent_rd_addr   = cur_ff[htw_pkg::ENT_AW-1:0];
      bkt_we        = 1'b0;
      bkt_wr_addr   = bkt_ff;
      bkt_wr_data   = '0;
      bkt_rd_addr   = bkt_ff;

      app_done = 1'b0;
      unl_done = 1'b0;
      lag      = now_ff - wheel_time_ff;
      lag_next = now_ff - (wheel_time_ff + SLOT_TICKS);
      id_idx   = id_ff[htw_pkg::ENT_AW-1:0];

      case (state_ff)
         // Empty every bucket after reset.
         S_CLEAR: begin
            bkt_we      = 1'b1;
            bkt_wr_addr = clr_ff;
            bkt_wr_data = '{head: htw_pkg::NIL, tail: htw_pkg::NIL};
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) state_in = S_IDLE;
         end

         S_IDLE: begin
            if (req.valid) begin
               op_in    = req.operation;
               id_in    = req.timer_sel;
               exp_in   = req.expire_time;
               now_in   = req.now_time;
               state_in = S_DECIDE;
            end
         end

         // Dispatch on the operation code.
         S_DECIDE: begin
            res_id_in     = id_ff;
            res_last_in   = 1'b1;
            res_behind_in = 1'b0;
            after_in      = S_IDLE;
            case (op_ff)
               htw_pkg::OP_ADD: begin
                  if (!htw_pkg::id_ok(id_ff) || pending_ff[id_idx]) begin
                     res_kind_in = htw_pkg::KIND_REJECTED;
                     state_in    = S_EMIT;
                  end else begin
                     ent_wr.we_exp = 1'b1;
                     ent_wr.addr   = id_idx;
                     ent_wr.expiry = exp_ff;
                     pending_in[id_idx] = 1'b1;
                     cur_in   = htw_pkg::PTR_W'(id_ff);
                     bkt_in   = htw_pkg::pick_bucket(exp_ff, wheel_time_ff, inner_ff);
                     ctx_in   = CTX_ADD;
                     state_in = S_APP_RD;
                  end
               end
               htw_pkg::OP_DELETE: begin
                  if (!htw_pkg::id_ok(id_ff) || !pending_ff[id_idx]) begin
                     res_kind_in = htw_pkg::KIND_IDLE;
                     state_in    = S_EMIT;
                  end else begin
                     cur_in   = htw_pkg::PTR_W'(id_ff);
                     ctx_in   = CTX_DEL;
                     state_in = S_UNL_RD;
                  end
               end
               htw_pkg::OP_TICK: begin
                  res_id_in = '0;
                  if (lag[htw_pkg::TIME_W-1]) begin
                     res_kind_in = htw_pkg::KIND_NOT_DUE;
                     state_in    = S_EMIT;
                  end else if (inner_ff == '0) begin
                     bkt_in       = htw_pkg::BKT_W'(htw_pkg::IN_SLOTS) +
                                    htw_pkg::BKT_W'(middle_ff);
                     middle_in    = middle_ff + 1'b1;
                     cas_outer_in = (middle_ff == '0);
                     state_in     = S_CAS_RD;
                  end else begin
                     state_in = S_EXP_START;
                  end
               end
               default: begin
                  res_kind_in = htw_pkg::KIND_NONE;
                  res_id_in   = '0;
                  state_in    = S_EMIT;
               end
            endcase
         end

         // Load the output register once it is free.
         S_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = res_kind_ff;
               rsp_id_in     = res_id_ff;
               rsp_last_in   = res_last_ff;
               rsp_behind_in = res_behind_ff;
               state_in      = after_ff;
            end
         end

         // Append cur to the tail of bucket bkt.
         S_APP_RD: begin
            state_in = S_APP_WR;
         end

         S_APP_WR: begin
            bkt_we           = 1'b1;
            bkt_wr_data.head = htw_pkg::ptr_ok(bkt_rd.tail) ? bkt_rd.head : cur_ff;
            bkt_wr_data.tail = cur_ff;
            ent_wr.we_next   = 1'b1;
            ent_wr.we_prev   = 1'b1;
            ent_wr.we_bkt    = 1'b1;
            ent_wr.addr      = cur_ff[htw_pkg::ENT_AW-1:0];
            ent_wr.next      = htw_pkg::NIL;
            ent_wr.prev      = bkt_rd.tail;
            ent_wr.bkt       = bkt_ff;
            prv_in           = bkt_rd.tail;
            if (htw_pkg::ptr_ok(bkt_rd.tail)) state_in = S_APP_LINK;
            else app_done = 1'b1;
         end

         S_APP_LINK: begin
            ent_wr.we_next = 1'b1;
            ent_wr.addr    = prv_ff[htw_pkg::ENT_AW-1:0];
            ent_wr.next    = cur_ff;
            app_done       = 1'b1;
         end

         // Unlink cur from its bucket.
         S_UNL_RD: begin
            state_in = S_UNL_BK;
         end

         S_UNL_BK: begin
            prv_in      = ent_rd.prev;
            nxt_in      = ent_rd.next;
            bkt_in      = ent_rd.bkt;
            bkt_rd_addr = ent_rd.bkt;
            state_in    = S_UNL_WR;
         end

         S_UNL_WR: begin
            bkt_we           = 1'b1;
            bkt_wr_data.head = (prv_ff == htw_pkg::NIL) ? nxt_ff : bkt_rd.head;
            bkt_wr_data.tail = (nxt_ff == htw_pkg::NIL) ? prv_ff : bkt_rd.tail;
            if (prv_ff != htw_pkg::NIL && htw_pkg::ptr_ok(prv_ff)) begin
               ent_wr.we_next = 1'b1;
               ent_wr.addr    = prv_ff[htw_pkg::ENT_AW-1:0];
               ent_wr.next    = nxt_ff;
            end
            state_in = S_UNL_LINK;
         end

         S_UNL_LINK: begin
            if (nxt_ff != htw_pkg::NIL && htw_pkg::ptr_ok(nxt_ff)) begin
               ent_wr.we_prev = 1'b1;
               ent_wr.addr    = nxt_ff[htw_pkg::ENT_AW-1:0];
               ent_wr.prev    = prv_ff;
            end
            unl_done = 1'b1;
         end

         // Cascade: detach bucket bkt and refile its entries in order.
         S_CAS_RD: begin
            state_in = S_CAS_DET;
         end

         S_CAS_DET: begin
            bkt_we      = 1'b1;
            bkt_wr_data = '{head: htw_pkg::NIL, tail: htw_pkg::NIL};
            cur_in      = bkt_rd.head;
            state_in    = S_CAS_CHK;
         end

         S_CAS_CHK: begin
            if (htw_pkg::ptr_ok(cur_ff)) begin
               state_in = S_CAS_FILE;
            end else if (cas_outer_ff) begin
               cas_outer_in = 1'b0;
               bkt_in       = htw_pkg::BKT_W'(htw_pkg::IN_SLOTS + htw_pkg::OUT_SLOTS) +
                              htw_pkg::BKT_W'(outer_ff);
               outer_in     = outer_ff + 1'b1;
               state_in     = S_CAS_RD;
            end else begin
               state_in = S_EXP_START;
            end
         end

         S_CAS_FILE: begin
            nxt_in   = ent_rd.next;
            bkt_in   = htw_pkg::pick_bucket(ent_rd.expiry, wheel_time_ff, inner_ff);
            ctx_in   = CTX_CAS;
            state_in = S_APP_RD;
         end

         // Advance one slot, then drain the slot just passed.
         S_EXP_START: begin
            bkt_in        = htw_pkg::BKT_W'(inner_ff);
            wheel_time_in = wheel_time_ff + SLOT_TICKS;
            inner_in      = inner_ff + 1'b1;
            behind_in     = !lag_next[htw_pkg::TIME_W-1];
            hold_valid_in = 1'b0;
            state_in      = S_EXP_RD;
         end

         S_EXP_RD: begin
            state_in = S_EXP_CHK;
         end

         S_EXP_CHK: begin
            cur_in        = bkt_rd.head;
            res_behind_in = behind_ff;
            res_id_in     = hold_id_ff;
            res_kind_in   = htw_pkg::KIND_EXPIRED;
            if (htw_pkg::ptr_ok(bkt_rd.head)) begin
               res_last_in = 1'b0;
               if (hold_valid_ff) begin
                  after_in = S_EXP_TAKE;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_EXP_TAKE;
               end
            end else begin
               res_last_in = 1'b1;
               after_in    = S_IDLE;
               state_in    = S_EMIT;
               if (!hold_valid_ff) begin
                  res_kind_in = htw_pkg::KIND_NONE;
                  res_id_in   = '0;
               end
            end
         end

         S_EXP_TAKE: begin
            hold_valid_in = 1'b1;
            hold_id_in    = cur_ff[htw_pkg::ID_W-1:0];
            ctx_in        = CTX_EXP;
            state_in      = S_UNL_RD;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Return from an append.
      if (app_done) begin
         if (ctx_ff == CTX_CAS) begin
            cur_in   = nxt_ff;
            state_in = S_CAS_CHK;
         end else begin
            res_kind_in   = htw_pkg::KIND_ADDED;
            res_id_in     = id_ff;
            res_last_in   = 1'b1;
            res_behind_in = 1'b0;
            after_in      = S_IDLE;
            state_in      = S_EMIT;
         end
      end

      // Return from an unlink.
      if (unl_done) begin
         pending_in[cur_ff[htw_pkg::ENT_AW-1:0]] = 1'b0;
         if (ctx_ff == CTX_DEL) begin
            res_kind_in   = htw_pkg::KIND_DELETED;
            res_id_in     = id_ff;
            res_last_in   = 1'b1;
            res_behind_in = 1'b0;
            after_in      = S_IDLE;
            state_in      = S_EMIT;
         end else begin
            state_in = S_EXP_RD;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         wheel_time_ff <= '0;
         inner_ff      <= '0;
         middle_ff     <= '0;
         outer_ff      <= '0;
         pending_ff    <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         wheel_time_ff <= wheel_time_in;
         inner_ff      <= inner_in;
         middle_ff     <= middle_in;
         outer_ff      <= outer_in;
         pending_ff    <= pending_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      after_ff      <= after_in;
      ctx_ff        <= ctx_in;
      op_ff         <= op_in;
      id_ff         <= id_in;
      exp_ff        <= exp_in;
      now_ff        <= now_in;
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      prv_ff        <= prv_in;
      bkt_ff        <= bkt_in;
      cas_outer_ff  <= cas_outer_in;
      hold_id_ff    <= hold_id_in;
      behind_ff     <= behind_in;
      res_kind_ff   <= res_kind_in;
      res_id_ff     <= res_id_in;
      res_last_ff   <= res_last_in;
      res_behind_ff <= res_behind_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_behind_ff <= rsp_behind_in;
   end

   assign req.ready     = (state_ff == S_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.kind      = rsp_kind_ff;
   assign rsp.timer_out = rsp_id_ff;
   assign rsp.last      = rsp_last_ff;
   assign rsp.behind    = rsp_behind_ff;

   // The inner index always tracks the slot field of wheel time.
   a_inner_tracks_time: assert property (@(posedge clock) disable iff (reset)
      inner_ff == wheel_time_ff[htw_pkg::SLOT_SHIFT +: htw_pkg::INNER_BITS])
      else $error("inner index out of step with wheel time");

   // An accepted request beat is dispatched in the next cycle.
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> state_ff == S_DECIDE)
      else $error("accepted request not dispatched");

   // A non-final expired beat names a timer that is no longer pending.
   a_expired_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.kind == htw_pkg::KIND_EXPIRED && !rsp.last
      |-> !pending_ff[rsp.timer_out[htw_pkg::ENT_AW-1:0]])
      else $error("expired timer still pending");

   // No response is produced while the bucket table is being cleared.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp.valid)
      else $error("response during bucket clear");

endmodule

>>> tb/hierarchical_timer_wheel_tb.sv
// Testbench for the hierarchical timer wheel: directed and random adds,
// deletes and ticks, checked beat by beat against a behavioral wheel.
// Depends on htw_pkg, htw_req_if, htw_rsp_if and hierarchical_timer_wheel.
module hierarchical_timer_wheel_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      htw_pkg::kind_type         kind;
      logic [htw_pkg::ID_W-1:0]  timer;
      logic                      last;
      logic                      behind;
   } wheel_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   htw_req_if req_ch ();
   htw_rsp_if rsp_ch ();

   hierarchical_timer_wheel dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #5 clock = ~clock;

   // Behavioral copy of the wheel.
   logic [htw_pkg::TIME_W-1:0] sh_expiry [htw_pkg::NUM_TIMERS];
   logic                       sh_pending [htw_pkg::NUM_TIMERS];
   logic [htw_pkg::PTR_W-1:0]  sh_next [htw_pkg::NUM_TIMERS];
   logic [htw_pkg::PTR_W-1:0]  sh_prev [htw_pkg::NUM_TIMERS];
   int                         sh_bucket [htw_pkg::NUM_TIMERS];
   logic [htw_pkg::PTR_W-1:0]  sh_head [htw_pkg::NBUCKETS];
   logic [htw_pkg::PTR_W-1:0]  sh_tail [htw_pkg::NBUCKETS];
   logic [htw_pkg::TIME_W-1:0] sh_wheel_time;
   int                         sh_inner, sh_middle, sh_outer;

   wheel_beat_type expected_beats [$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          hold_off = 0;
   int          rx_mode = 0;
   int          burst_left = 0;

   function automatic void shadow_reset();
      for (int i = 0; i < htw_pkg::NUM_TIMERS; i++) begin
         sh_expiry[i] = '0;
         sh_pending[i] = 1'b0;
         sh_next[i] = htw_pkg::NIL;
         sh_prev[i] = htw_pkg::NIL;
         sh_bucket[i] = -1;
      end
      for (int i = 0; i < htw_pkg::NBUCKETS; i++) begin
         sh_head[i] = htw_pkg::NIL;
         sh_tail[i] = htw_pkg::NIL;
      end
      sh_wheel_time = '0;
      sh_inner = 0;
      sh_middle = 0;
      sh_outer = 0;
   endfunction

   function automatic void shadow_append(int b, int t);
      logic [htw_pkg::PTR_W-1:0] tl;
      tl = sh_tail[b];
      sh_next[t] = htw_pkg::NIL;
      sh_prev[t] = tl;
      sh_bucket[t] = b;
      if (tl == htw_pkg::NIL) sh_head[b] = htw_pkg::PTR_W'(t);
      else sh_next[tl] = htw_pkg::PTR_W'(t);
      sh_tail[b] = htw_pkg::PTR_W'(t);
   endfunction

   function automatic void shadow_unlink(int t);
      int b;
      logic [htw_pkg::PTR_W-1:0] p, n;
      b = sh_bucket[t];
      p = sh_prev[t];
      n = sh_next[t];
      if (b >= 0) begin
         if (p == htw_pkg::NIL) sh_head[b] = n;
         else if (p < htw_pkg::NUM_TIMERS) sh_next[p] = n;
         if (n == htw_pkg::NIL) sh_tail[b] = p;
         else if (n < htw_pkg::NUM_TIMERS) sh_prev[n] = p;
      end
      sh_next[t] = htw_pkg::NIL;
      sh_prev[t] = htw_pkg::NIL;
      sh_bucket[t] = -1;
   endfunction

   // Level and slot selection from the distance to wheel time.
   function automatic void shadow_file(int t);
      logic [htw_pkg::TIME_W-1:0] e, d;
      int b;
      e = sh_expiry[t];
      d = e - sh_wheel_time;
      if (d < 32'h0001_0000) b = int'((e >> 6) & 32'd1023);
      else if (d < 32'h0100_0000) b = htw_pkg::IN_SLOTS + int'((e >> 16) & 32'd255);
      else if (d[31]) b = sh_inner;
      else b = htw_pkg::IN_SLOTS + htw_pkg::OUT_SLOTS + int'((e >> 24) & 32'd255);
      shadow_append(b, t);
   endfunction

   function automatic void shadow_cascade(int b);
      logic [htw_pkg::PTR_W-1:0] t, n;
      t = sh_head[b];
      sh_head[b] = htw_pkg::NIL;
      sh_tail[b] = htw_pkg::NIL;
      while (t < htw_pkg::NUM_TIMERS) begin
         n = sh_next[t];
         shadow_file(int'(t));
         t = n;
      end
   endfunction

   function automatic wheel_beat_type mk_beat(htw_pkg::kind_type k, int id, logic bh);
      wheel_beat_type r;
      r.kind = k;
      r.timer = htw_pkg::ID_W'(id);
      r.last = 1'b0;
      r.behind = bh;
      return r;
   endfunction

   // Work out the beats one request causes and queue them.
   function automatic void predict_wheel(htw_pkg::op_type op,
                                         logic [htw_pkg::ID_W-1:0] id,
                                         logic [htw_pkg::TIME_W-1:0] e,
                                         logic [htw_pkg::TIME_W-1:0] now);
      wheel_beat_type beats [$];
      logic [htw_pkg::TIME_W-1:0] gap;
      logic [htw_pkg::PTR_W-1:0] t;
      logic bh;
      int b;
      case (op)
         htw_pkg::OP_ADD: begin
            if (sh_pending[id])
               beats.push_back(mk_beat(htw_pkg::KIND_REJECTED, id, 1'b0));
            else begin
               sh_expiry[id] = e;
               sh_pending[id] = 1'b1;
               shadow_file(int'(id));
               beats.push_back(mk_beat(htw_pkg::KIND_ADDED, id, 1'b0));
            end
         end
         htw_pkg::OP_DELETE: begin
            if (!sh_pending[id])
               beats.push_back(mk_beat(htw_pkg::KIND_IDLE, id, 1'b0));
            else begin
               shadow_unlink(int'(id));
               sh_pending[id] = 1'b0;
               beats.push_back(mk_beat(htw_pkg::KIND_DELETED, id, 1'b0));
            end
         end
         htw_pkg::OP_TICK: begin
            gap = now - sh_wheel_time;
            if (gap[31]) beats.push_back(mk_beat(htw_pkg::KIND_NOT_DUE, 0, 1'b0));
            else begin
               if (sh_inner == 0) begin
                  shadow_cascade(htw_pkg::IN_SLOTS + sh_middle);
                  sh_middle = (sh_middle + 1) % htw_pkg::OUT_SLOTS;
                  if (sh_middle == 1) begin
                     shadow_cascade(htw_pkg::IN_SLOTS + htw_pkg::OUT_SLOTS + sh_outer);
                     sh_outer = (sh_outer + 1) % htw_pkg::OUT_SLOTS;
                  end
               end
               b = sh_inner;
               sh_wheel_time = sh_wheel_time + 32'd64;
               sh_inner = (sh_inner + 1) % htw_pkg::IN_SLOTS;
               gap = now - sh_wheel_time;
               bh = ~gap[31];
               t = sh_head[b];
               while (t < htw_pkg::NUM_TIMERS && beats.size() < htw_pkg::NUM_TIMERS) begin
                  shadow_unlink(int'(t));
                  sh_pending[t] = 1'b0;
                  beats.push_back(mk_beat(htw_pkg::KIND_EXPIRED, int'(t), bh));
                  t = sh_head[b];
               end
               if (beats.size() == 0) beats.push_back(mk_beat(htw_pkg::KIND_NONE, 0, bh));
            end
         end
         default: beats.push_back(mk_beat(htw_pkg::KIND_NONE, 0, 1'b0));
      endcase
      beats[beats.size()-1].last = 1'b1;
      foreach (beats[i]) expected_beats.push_back(beats[i]);
   endfunction

   // Send one request beat, then maybe open a gap between bursts.
   task automatic send_request(htw_pkg::op_type op, logic [htw_pkg::ID_W-1:0] id,
                               logic [htw_pkg::TIME_W-1:0] e,
                               logic [htw_pkg::TIME_W-1:0] now);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.timer_sel <= id;
      req_ch.expire_time <= e;
      req_ch.now_time <= now;
      do @(posedge clock); while (!req_ch.ready);
      predict_wheel(op, id, e, now);
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 12);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic tick_due(logic [htw_pkg::TIME_W-1:0] ahead);
      send_request(htw_pkg::OP_TICK, '0, '0, sh_wheel_time + ahead);
   endtask

   // Stop offering and wait until every queued beat has come back.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Directed adds and deletes over every filing level and the extremes.
   task automatic test_add_delete();
      send_request(htw_pkg::OP_ADD, 6'd0, 32'h0000_0000, '0);
      send_request(htw_pkg::OP_ADD, 6'd63, 32'hFFFF_FFFF, '0);
      send_request(htw_pkg::OP_ADD, 6'd63, 32'h0000_1000, '0);
      send_request(htw_pkg::OP_ADD, 6'd5, 32'h0001_0000, '0);
      send_request(htw_pkg::OP_ADD, 6'd6, 32'h7F00_0000, '0);
      send_request(htw_pkg::OP_ADD, 6'd7, 32'h8000_0000, '0);
      send_request(htw_pkg::OP_ADD, 6'd8, 32'h0000_0040, '0);
      send_request(htw_pkg::OP_DELETE, 6'd9, '0, '0);
      send_request(htw_pkg::OP_DELETE, 6'd5, '0, '0);
      send_request(htw_pkg::OP_DELETE, 6'd5, '0, '0);
      send_request(htw_pkg::OP_ADD, 6'd42, 32'h0000_003F, '0);
   endtask

   // Directed ticks: not due, due with several expiries, empty, unused code.
   task automatic test_ticks();
      send_request(htw_pkg::OP_TICK, '0, '0, 32'h8000_0000);
      send_request(htw_pkg::OP_TICK, '0, '0, 32'hFFFF_FFFF);
      send_request(htw_pkg::OP_TICK, '0, '0, 32'h0000_0000);
      tick_due(32'h7FFF_FFFF);
      tick_due(32'd64);
      tick_due(32'd0);
      send_request(htw_pkg::OP_UNUSED, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(htw_pkg::OP_UNUSED, '0, '0, '0);
      drain();
   endtask

   // Random traffic: mostly adds, most of them near-future, with ticks to expire them.
   task automatic test_random(int count);
      int sel;
      logic [htw_pkg::ID_W-1:0] id;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         id = htw_pkg::ID_W'($urandom_range(0, 63));
         if (sel < 45) send_request(htw_pkg::OP_ADD, id,
                                    sh_wheel_time + $urandom_range(0, 1500), $urandom);
         else if (sel < 52) send_request(htw_pkg::OP_ADD, id, $urandom, $urandom);
         else if (sel < 62) send_request(htw_pkg::OP_DELETE, id, $urandom, $urandom);
         else if (sel < 90) tick_due($urandom_range(0, 300));
         else if (sel < 95) send_request(htw_pkg::OP_TICK, id, $urandom, $urandom);
         else send_request(htw_pkg::OP_UNUSED, id, $urandom, $urandom);
      end
   endtask

   // Long receiver hold-off while requests keep coming.
   task automatic test_backpressure();
      hold_off = 400;
      for (int i = 0; i < 8; i++)
         send_request(htw_pkg::OP_ADD, htw_pkg::ID_W'(i + 20), sh_wheel_time + 32'd10, '0);
      for (int i = 0; i < 6; i++) tick_due(32'd5);
      drain();
   endtask

   // Receiver: check each accepted beat and choose the next stall.
   always @(posedge clock) begin
      wheel_beat_type w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat kind=%0d timer=%0d", rsp_ch.kind, rsp_ch.timer_out);
         end else begin
            w = expected_beats.pop_front();
            if (rsp_ch.kind !== w.kind || rsp_ch.timer_out !== w.timer ||
                rsp_ch.last !== w.last || rsp_ch.behind !== w.behind) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp kind=%0d timer=%0d last=%0b behind=%0b,",
                           w.kind, w.timer, w.last, w.behind,
                           " got kind=%0d timer=%0d last=%0b behind=%0b",
                           rsp_ch.kind, rsp_ch.timer_out, rsp_ch.last, rsp_ch.behind);
            end
         end
      end
      if ($urandom_range(0, 63) == 0) rx_mode = $urandom_range(0, 2);
      if (hold_off > 0) begin
         hold_off--;
         rsp_ch.ready <= 1'b0;
      end else if (rx_mode == 0) rsp_ch.ready <= 1'b1;
      else if (rx_mode == 1) rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      else rsp_ch.ready <= ($urandom_range(0, 1) != 0);
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.operation = htw_pkg::OP_ADD;
      req_ch.timer_sel = '0;
      req_ch.expire_time = '0;
      req_ch.now_time = '0;
      rsp_ch.ready = 1'b0;
      shadow_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_add_delete();
      test_ticks();
      test_backpressure();
      test_random(197);
      req_ch.valid <= 1'b0;
      drain();
      if (mismatches == 0 && expected_beats.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
